### hw/rtl/clp_pkg.sv
package clp_pkg;

  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_WRITE_CHAR = 3'd1,
    CMD_SET_CURSOR = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_HOME       = 3'd4,
    CMD_DISPLAY_EN = 3'd5,
    CMD_CURSOR_EN  = 3'd6,
    CMD_BLINK_EN   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_ERR  = 2'd0,
    JOB_INIT = 2'd1,
    JOB_BYTE = 2'd2
  } job_kind_e;

  localparam logic [2:0]  FLAG_DISPLAY = 3'b100;
  localparam logic [2:0]  FLAG_CURSOR  = 3'b010;
  localparam logic [2:0]  FLAG_BLINK   = 3'b001;

  localparam logic [7:0]  BYTE_CLEAR   = 8'h01;
  localparam logic [7:0]  BYTE_HOME    = 8'h02;

  localparam logic [15:0] PRE_POWER_UP = 16'd50000;
  localparam logic [12:0] POST_HIGH    = 13'd50;
  localparam logic [12:0] POST_DATA    = 13'd100;
  localparam logic [12:0] POST_INSTR   = 13'd150;
  localparam logic [12:0] POST_SLOW    = 13'd2150;

  localparam logic [3:0]  INIT_LAST    = 4'd15;

  // One queued request, ready for the strobe sequencer.
  typedef struct packed {
    job_kind_e   kind;
    logic        rs;
    logic [7:0]  data;
    logic [12:0] post_low;
  } job_t;

  typedef struct packed {
    logic        strobe_valid;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] pre_wait_us;
    logic [12:0] post_wait_us;
    logic        status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [15:0] pre_wait_us;
    logic [12:0] post_wait_us;
  } init_ent_t;

  // Power-up strobe sequence: three wake-up nibbles, the switch to 4-bit mode,
  // then function set, display setup, clear and entry mode as byte pairs.
  function automatic init_ent_t init_entry(input logic [3:0] idx);
    init_ent_t e;
    e.pre_wait_us = '0;
    unique case (idx)
      4'd0: begin
        e.nibble = 4'h3; e.pre_wait_us = PRE_POWER_UP; e.post_wait_us = 13'd4550;
      end
      4'd1:  begin e.nibble = 4'h3; e.post_wait_us = 13'd200;  end
      4'd2:  begin e.nibble = 4'h3; e.post_wait_us = POST_HIGH; end
      4'd3:  begin e.nibble = 4'h2; e.post_wait_us = POST_DATA; end
      4'd4:  begin e.nibble = 4'h2; e.post_wait_us = POST_HIGH; end
      4'd5:  begin e.nibble = 4'h8; e.post_wait_us = POST_INSTR; end
      4'd6:  begin e.nibble = 4'h0; e.post_wait_us = POST_HIGH; end
      4'd7:  begin e.nibble = 4'hF; e.post_wait_us = POST_INSTR; end
      4'd8:  begin e.nibble = 4'h0; e.post_wait_us = POST_HIGH; end
      4'd9:  begin e.nibble = 4'hD; e.post_wait_us = POST_INSTR; end
      4'd10: begin e.nibble = 4'h0; e.post_wait_us = POST_HIGH; end
      4'd11: begin e.nibble = 4'hC; e.post_wait_us = POST_INSTR; end
      4'd12: begin e.nibble = 4'h0; e.post_wait_us = POST_HIGH; end
      4'd13: begin e.nibble = 4'h1; e.post_wait_us = 13'd4150; end
      4'd14: begin e.nibble = 4'h0; e.post_wait_us = POST_HIGH; end
      4'd15: begin e.nibble = 4'h6; e.post_wait_us = POST_INSTR; end
    endcase
    return e;
  endfunction

endpackage

### hw/rtl/clp_front.sv
module clp_front import clp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [2:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] column_i,
  input  logic [1:0] row_i,
  input  logic       enable_i,
  output logic       job_valid_o,
  output job_t       job_o,
  input  logic       job_pop_i
);

  logic       init_q, init_d;
  logic [2:0] flags_q, flags_d;
  logic [2:0] mask;
  job_t       jb;
  logic       accept;
  cmd_e       cmd;

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign cmd    = cmd_e'(command_i);
  assign full_o = (cnt_q == 2'd2);
  assign accept = push_i && !full_o;

  always_comb begin
    jb.kind     = JOB_BYTE;
    jb.rs       = 1'b0;
    jb.data     = '0;
    jb.post_low = POST_INSTR;
    init_d      = init_q;
    flags_d     = flags_q;
    mask        = '0;
    if (cmd == CMD_INIT) begin
      jb.kind = JOB_INIT;
      init_d  = 1'b1;
      flags_d = FLAG_DISPLAY;
    end else if (!init_q) begin
      jb.kind = JOB_ERR;
    end else begin
      unique case (cmd)
        CMD_INIT: ;
        CMD_WRITE_CHAR: begin
          jb.rs       = 1'b1;
          jb.data     = char_code_i;
          jb.post_low = POST_DATA;
        end
        CMD_SET_CURSOR: jb.data = {1'b1, (row_i == 2'd1), column_i};
        CMD_CLEAR: begin
          jb.data     = BYTE_CLEAR;
          jb.post_low = POST_SLOW;
        end
        CMD_HOME: begin
          jb.data     = BYTE_HOME;
          jb.post_low = POST_SLOW;
        end
        CMD_DISPLAY_EN, CMD_CURSOR_EN, CMD_BLINK_EN: begin
          mask = (cmd == CMD_DISPLAY_EN) ? FLAG_DISPLAY :
                 (cmd == CMD_CURSOR_EN)  ? FLAG_CURSOR  : FLAG_BLINK;
          flags_d = enable_i ? (flags_q | mask) : (flags_q & ~mask);
          jb.data = {5'b00001, flags_d};
        end
      endcase
    end
    if (!accept) begin
      init_d  = init_q;
      flags_d = flags_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= 1'b0;
      flags_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      init_q  <= init_d;
      flags_q <= flags_d;
      if (accept) wr_ptr_q <= ~wr_ptr_q;
      if (job_pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (accept && !job_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!accept && job_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) slot_q[wr_ptr_q] <= jb;
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = slot_q[rd_ptr_q];

endmodule

### hw/rtl/clp_back.sv
module clp_back import clp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  job_t       cur_q;
  logic       active_q;
  logic [3:0] step_q;
  res_t       res;
  init_ent_t  ie;
  logic       is_last;
  logic       emit;
  logic       popped;

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign ie = init_entry(step_q);

  always_comb begin
    res.strobe_valid = 1'b1;
    res.reg_select   = cur_q.rs;
    res.nibble       = step_q[0] ? cur_q.data[3:0] : cur_q.data[7:4];
    res.pre_wait_us  = '0;
    res.post_wait_us = step_q[0] ? cur_q.post_low : POST_HIGH;
    res.status       = 1'b0;
    is_last          = step_q[0];
    unique case (cur_q.kind)
      JOB_ERR: begin
        res.strobe_valid = 1'b0;
        res.reg_select   = 1'b0;
        res.nibble       = '0;
        res.post_wait_us = '0;
        res.status       = 1'b1;
        is_last          = 1'b1;
      end
      JOB_INIT: begin
        res.reg_select   = 1'b0;
        res.nibble       = ie.nibble;
        res.pre_wait_us  = ie.pre_wait_us;
        res.post_wait_us = ie.post_wait_us;
        is_last          = (step_q == INIT_LAST);
      end
      JOB_BYTE: ;
      default: ;
    endcase
    res.last = is_last;
  end

  assign emit      = active_q && (cnt_q != 2'd2);
  assign popped    = pop_i && !empty_o;
  // The next job loads in the same cycle the current one emits its last word.
  assign job_pop_o = job_valid_i && (!active_q || (emit && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (job_pop_o) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (emit) begin
        if (is_last) active_q <= 1'b0;
        step_q <= step_q + 4'd1;
      end
      if (emit) wr_ptr_q <= ~wr_ptr_q;
      if (popped) rd_ptr_q <= ~rd_ptr_q;
      if (emit && !popped) cnt_q <= cnt_q + 2'd1;
      else if (!emit && popped) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) cur_q <= job_i;
    if (emit) slot_q[wr_ptr_q] <= res;
  end

  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = slot_q[rd_ptr_q];

endmodule

### hw/rtl/char_lcd_nibble_interface_unit.sv
// Request sequencer for a 4-bit character LCD. Each request (init, write
// character, set cursor, clear, home, display/cursor/blink enable) becomes a
// run of result words, one per enable strobe, each with RS level, nibble and
// the microsecond waits before and after; the timing itself is done
// downstream. The front accepts one request per cycle, unless full, into a
// two-entry job queue; the strobe sequencer behind it emits one word per
// cycle, unless its two-entry result queue is full. A byte request becomes
// two words, init sixteen, and a request made before init one error word. No
// clearing pass follows reset; requests are taken from the first cycle after reset.
module char_lcd_nibble_interface_unit import clp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  column_i,
  input  logic [1:0]  row_i,
  input  logic        enable_i,
  output logic        empty,
  input  logic        pop,
  output logic        strobe_valid_o,
  output logic        reg_select_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] pre_wait_us_o,
  output logic [12:0] post_wait_us_o,
  output logic        status_o,
  output logic        last_o
);

  logic job_valid;
  logic job_pop;
  job_t job;
  res_t res;

  clp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .enable_i    (enable_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  clp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign strobe_valid_o = res.strobe_valid;
  assign reg_select_o   = res.reg_select;
  assign nibble_o       = res.nibble;
  assign pre_wait_us_o  = res.pre_wait_us;
  assign post_wait_us_o = res.post_wait_us;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule

### hw/rtl/clp_checker.sv
module clp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        strobe_valid_o,
  input logic        reg_select_o,
  input logic [3:0]  nibble_o,
  input logic [15:0] pre_wait_us_o,
  input logic [12:0] post_wait_us_o,
  input logic        status_o,
  input logic        last_o
);

  // An error word stands alone and carries no strobe.
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (last_o && !strobe_valid_o && post_wait_us_o == 13'd0))
    else $error("error word malformed");

  // Only the first power-up strobe waits before it.
  a_pre_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pre_wait_us_o != 16'd0) |->
      (pre_wait_us_o == 16'd50000 && nibble_o == 4'h3 && !reg_select_o && !last_o))
    else $error("unexpected pre-strobe wait");

  // Data strobes use the data byte timing.
  a_data_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reg_select_o) |->
      (strobe_valid_o && (post_wait_us_o == 13'd50 || post_wait_us_o == 13'd100)))
    else $error("data strobe with wrong post wait");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(nibble_o) && $stable(post_wait_us_o)
                          && $stable(last_o)))
    else $error("waiting word changed");

endmodule

bind char_lcd_nibble_interface_unit clp_checker u_clp_checker (.*);
